FILE: rtl/pzv_pkg.sv
// Shared definitions for the pan/zoom viewport block.
// Holds event codes, register indexes, controller/datapath structs and width helpers.
// No dependencies.
package pzv_pkg;

    localparam int SCALE_W         = 24;
    localparam int KIND_W          = 3;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_COORD_WIDTH = 48;

    // event kinds
    localparam logic [KIND_W-1:0] K_DRAG_BEGIN = 3'd0;
    localparam logic [KIND_W-1:0] K_DRAG_MOVE  = 3'd1;
    localparam logic [KIND_W-1:0] K_DRAG_END   = 3'd2;
    localparam logic [KIND_W-1:0] K_PAN        = 3'd3;
    localparam logic [KIND_W-1:0] K_ZOOM       = 3'd4;
    localparam logic [KIND_W-1:0] K_SET_SCALE  = 3'd5;
    localparam logic [KIND_W-1:0] K_TO_SCREEN  = 3'd6;
    localparam logic [KIND_W-1:0] K_TO_CANVAS  = 3'd7;

    // configuration register indexes
    localparam logic CFG_ZOOM_MIN = 1'b0;
    localparam logic CFG_ZOOM_MAX = 1'b1;

    typedef struct packed {
        logic load_in;
        logic load_prod;
        logic load_ns;
        logic start;
        logic save_t;
        logic write_res;
        logic commit;
        logic axis;
        logic phase;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              drag;
        logic              scale_diff;
        logic              arith_done;
        logic              out_free;
    } t_stat;

    // signed width of the mul/div unit result
    function automatic int pzv_res_w(input int cw, input int fb);
        int nb;
        int mw;
        nb = cw + 1 + fb;
        mw = cw + 1 + SCALE_W - fb;
        return ((nb > mw) ? nb : mw) + 1;
    endfunction

endpackage

FILE: rtl/pzv_arith.sv
// Iterative signed multiply/divide by the scale, one bit per cycle.
// Divide: (a << FRAC_BITS) / s; multiply: (a * s) >> FRAC_BITS; both truncate toward zero.
// Depends on pzv_pkg.
module pzv_arith import pzv_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    localparam int RW = pzv_res_w(COORD_WIDTH, FRAC_BITS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_mul,
    input  logic signed [COORD_WIDTH:0] i_a,
    input  logic [SCALE_W-1:0]        i_s,
    output logic                      o_done,
    output logic signed [RW-1:0]      o_res
);

    localparam int MAGW  = COORD_WIDTH + 1;
    localparam int NB    = MAGW + FRAC_BITS;
    localparam int MW    = MAGW + SCALE_W;
    localparam int CNT_W = $clog2(NB);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_mul;
    logic                r_neg;
    logic [SCALE_W-1:0]  r_s;
    logic [SCALE_W-1:0]  r_rem;
    logic [NB-1:0]       r_dq;
    logic [MW-1:0]       r_acc;
    logic [MW-1:0]       r_mcand;
    logic [SCALE_W-1:0]  r_mplier;

    logic signed [COORD_WIDTH+1:0] a_ext;
    logic [COORD_WIDTH+1:0]        a_abs;
    logic [MAGW-1:0]               mag;
    logic [SCALE_W:0]              rem_sh;
    logic [SCALE_W:0]              rem_sub;
    logic                          ge;
    logic [RW-1:0]                 mag_res;

    assign a_ext   = {i_a[COORD_WIDTH], i_a};
    assign a_abs   = i_a[COORD_WIDTH] ? $unsigned(-a_ext) : $unsigned(a_ext);
    assign mag     = a_abs[MAGW-1:0];
    assign rem_sh  = {r_rem, r_dq[NB-1]};
    assign rem_sub = rem_sh - {1'b0, r_s};
    assign ge      = (rem_sh >= {1'b0, r_s});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_mul ? CNT_W'(SCALE_W - 1) : CNT_W'(NB - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mul    <= i_mul;
            r_neg    <= i_a[COORD_WIDTH];
            r_s      <= (i_s == '0) ? SCALE_W'(1) : i_s;
            r_rem    <= '0;
            r_dq     <= {mag, {FRAC_BITS{1'b0}}};
            r_acc    <= '0;
            r_mcand  <= MW'(mag);
            r_mplier <= i_s;
        end else if (r_busy) begin
            if (r_mul) begin
                r_acc    <= r_acc + (r_mplier[0] ? r_mcand : '0);
                r_mcand  <= {r_mcand[MW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[SCALE_W-1:1]};
            end else begin
                r_rem <= ge ? rem_sub[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
                r_dq  <= {r_dq[NB-2:0], ge};
            end
        end
    end

    assign mag_res = r_mul ? RW'(r_acc >> FRAC_BITS) : RW'(r_dq);
    assign o_res   = r_neg ? -$signed(mag_res) : $signed(mag_res);
    assign o_done  = r_done;

endmodule

FILE: rtl/pzv_dp.sv
// Datapath: viewport state, limit registers, operand selection, result register.
// Instantiates pzv_arith; driven by pzv_ctrl through t_cmd. Depends on pzv_pkg.
module pzv_dp import pzv_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_stat                  o_stat,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_index,
    input  logic [SCALE_W-1:0]     i_cfg_data,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [COORD_WIDTH-1:0] i_x,
    input  logic [COORD_WIDTH-1:0] i_y,
    input  logic [SCALE_W-1:0]     i_amt,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [COORD_WIDTH-1:0] o_out_x,
    output logic [COORD_WIDTH-1:0] o_out_y,
    output logic [COORD_WIDTH-1:0] o_org_x,
    output logic [COORD_WIDTH-1:0] o_org_y,
    output logic [SCALE_W-1:0]     o_zoom,
    output logic                   o_drag,
    output logic                   o_moved
);

    localparam int CW = COORD_WIDTH;
    localparam int RW = pzv_res_w(COORD_WIDTH, FRAC_BITS);
    localparam int SW = RW + 2;
    localparam int PW = 2 * SCALE_W;
    localparam logic [63:0] ONE   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] SMASK = (64'd1 << SCALE_W) - 64'd1;
    localparam logic [SCALE_W-1:0] SC_RST   = SCALE_W'((ONE > SMASK) ? SMASK : ONE);
    localparam logic [SCALE_W-1:0] ZMIN_RST = SCALE_W'((ONE + 64'd5) / 64'd10);
    localparam logic [SCALE_W-1:0] ZMAX_RST = SCALE_W'(((ONE << 2) > SMASK) ? SMASK : (ONE << 2));

    logic [SCALE_W-1:0] r_zmin, r_zmax, r_scale;
    logic [CW-1:0]      r_vx, r_vy, r_gcx, r_gcy, r_gvx, r_gvy;
    logic               r_drag;
    logic               r_pvld;
    logic               r_ovalid;

    logic [KIND_W-1:0]  r_kind;
    logic [CW-1:0]      r_x, r_y, r_pvx, r_pvy, r_ox, r_oy;
    logic [SCALE_W-1:0] r_amt, r_ns;
    logic [PW-1:0]      r_prod;
    logic signed [SW-1:0] r_t;
    logic [CW-1:0]      r_o_x, r_o_y, r_o_vx, r_o_vy;
    logic [SCALE_W-1:0] r_o_zoom;
    logic               r_o_drag, r_o_moved;

    logic [CW-1:0]         pt, vw, gc, gv;
    logic signed [CW:0]    a_op;
    logic                  ar_done;
    logic signed [RW-1:0]  ar_res;
    logic signed [SW-1:0]  q_s, vw_s, gv_s, expr, t_sum;
    logic [CW-1:0]         res_sat;
    logic [PW-1:0]         zreq;
    logic [SCALE_W-1:0]    zcl, ns_val;
    logic                  is_scale_kind, scale_upd;
    logic [CW-1:0]         nvx, nvy;
    logic [SCALE_W-1:0]    nsc;
    logic                  out_free;

    function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
        logic fits;
        fits = (&v[SW-1:CW-1]) | ~(|v[SW-1:CW-1]);
        if (fits) begin
            return v[CW-1:0];
        end else if (v[SW-1]) begin
            return {1'b1, {(CW-1){1'b0}}};
        end else begin
            return {1'b0, {(CW-1){1'b1}}};
        end
    endfunction

    assign pt = i_cmd.axis ? r_y : r_x;
    assign vw = i_cmd.axis ? r_vy : r_vx;
    assign gc = i_cmd.axis ? r_gcy : r_gcx;
    assign gv = i_cmd.axis ? r_gvy : r_gvx;

    always_comb begin
        case (r_kind)
            K_DRAG_MOVE: a_op = $signed({pt[CW-1], pt}) - $signed({gc[CW-1], gc});
            K_TO_SCREEN: a_op = $signed({pt[CW-1], pt}) - $signed({vw[CW-1], vw});
            default:     a_op = $signed({pt[CW-1], pt});
        endcase
    end

    pzv_arith #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_mul   (r_kind == K_TO_SCREEN),
        .i_a     (a_op),
        .i_s     (i_cmd.phase ? r_ns : r_scale),
        .o_done  (ar_done),
        .o_res   (ar_res)
    );

    assign q_s   = {{(SW-RW){ar_res[RW-1]}}, ar_res};
    assign vw_s  = {{(SW-CW){vw[CW-1]}}, vw};
    assign gv_s  = {{(SW-CW){gv[CW-1]}}, gv};
    assign t_sum = q_s + vw_s;

    always_comb begin
        case (r_kind)
            K_DRAG_MOVE: expr = gv_s - q_s;
            K_PAN:       expr = vw_s - q_s;
            K_TO_CANVAS: expr = t_sum;
            K_TO_SCREEN: expr = q_s;
            default:     expr = r_t - q_s;
        endcase
    end
    assign res_sat = sat(expr);

    // scale request and clamp: the minimum is tested first and wins if limits cross
    assign zreq = (r_kind == K_ZOOM) ? (r_prod >> FRAC_BITS) : PW'(r_amt);
    always_comb begin
        if (zreq < PW'(r_zmin)) begin
            zcl = r_zmin;
        end else if (zreq > PW'(r_zmax)) begin
            zcl = r_zmax;
        end else begin
            zcl = zreq[SCALE_W-1:0];
        end
        ns_val = (zcl == '0) ? SCALE_W'(1) : zcl;
    end

    assign is_scale_kind = (r_kind == K_ZOOM) || (r_kind == K_SET_SCALE);
    assign scale_upd     = is_scale_kind && (r_ns != r_scale);
    assign nvx           = r_pvld ? r_pvx : r_vx;
    assign nvy           = r_pvld ? r_pvy : r_vy;
    assign nsc           = scale_upd ? r_ns : r_scale;
    assign out_free      = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zmin   <= ZMIN_RST;
            r_zmax   <= ZMAX_RST;
            r_scale  <= SC_RST;
            r_vx     <= '0;
            r_vy     <= '0;
            r_gcx    <= '0;
            r_gcy    <= '0;
            r_gvx    <= '0;
            r_gvy    <= '0;
            r_drag   <= 1'b0;
            r_pvld   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ZOOM_MIN) begin
                    r_zmin <= i_cfg_data;
                end else begin
                    r_zmax <= i_cfg_data;
                end
            end
            if (i_cmd.load_in) begin
                r_pvld <= 1'b0;
            end else if (i_cmd.write_res && r_kind != K_TO_SCREEN && r_kind != K_TO_CANVAS) begin
                r_pvld <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_vx     <= nvx;
                r_vy     <= nvy;
                r_scale  <= nsc;
                r_ovalid <= 1'b1;
                if (r_kind == K_DRAG_BEGIN) begin
                    r_drag <= 1'b1;
                    r_gcx  <= r_x;
                    r_gcy  <= r_y;
                    r_gvx  <= r_vx;
                    r_gvy  <= r_vy;
                end else if (r_kind == K_DRAG_END) begin
                    r_drag <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind <= i_kind;
            r_x    <= i_x;
            r_y    <= i_y;
            r_amt  <= i_amt;
            r_ox   <= '0;
            r_oy   <= '0;
        end
        if (i_cmd.load_prod) begin
            r_prod <= r_scale * r_amt;
        end
        if (i_cmd.load_ns) begin
            r_ns <= ns_val;
        end
        if (i_cmd.save_t) begin
            r_t <= t_sum;
        end
        if (i_cmd.write_res) begin
            if (r_kind == K_TO_SCREEN || r_kind == K_TO_CANVAS) begin
                if (i_cmd.axis) r_oy <= res_sat;
                else            r_ox <= res_sat;
            end else begin
                if (i_cmd.axis) r_pvy <= res_sat;
                else            r_pvx <= res_sat;
            end
        end
        if (i_cmd.commit) begin
            r_o_x     <= r_ox;
            r_o_y     <= r_oy;
            r_o_vx    <= nvx;
            r_o_vy    <= nvy;
            r_o_zoom  <= nsc;
            r_o_drag  <= (r_kind == K_DRAG_BEGIN) ? 1'b1 :
                         (r_kind == K_DRAG_END)   ? 1'b0 : r_drag;
            r_o_moved <= (nvx != r_vx) || (nvy != r_vy) || (nsc != r_scale);
        end
    end

    assign o_stat.kind       = r_kind;
    assign o_stat.drag       = r_drag;
    assign o_stat.scale_diff = (r_ns != r_scale);
    assign o_stat.arith_done = ar_done;
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_ovalid;
    assign o_out_x     = r_o_x;
    assign o_out_y     = r_o_y;
    assign o_org_x     = r_o_vx;
    assign o_org_y     = r_o_vy;
    assign o_zoom      = r_o_zoom;
    assign o_drag      = r_o_drag;
    assign o_moved     = r_o_moved;

endmodule

FILE: rtl/pzv_ctrl.sv
// Controller: sequences one event through scale clamp, per-axis mul/div and commit.
// Drives pzv_dp through t_cmd and reads t_stat. Depends on pzv_pkg.
module pzv_ctrl import pzv_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PROD   = 3'd1;
    localparam logic [2:0] S_CLAMP  = 3'd2;
    localparam logic [2:0] S_DISP   = 3'd3;
    localparam logic [2:0] S_START  = 3'd4;
    localparam logic [2:0] S_WAIT   = 3'd5;
    localparam logic [2:0] S_COMMIT = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_axis, n_axis;
    logic       r_phase, n_phase;
    logic       scale_kind;
    logic       need_arith;

    assign scale_kind = (i_stat.kind == K_ZOOM) || (i_stat.kind == K_SET_SCALE);
    assign need_arith = (i_stat.kind == K_DRAG_MOVE && i_stat.drag) ||
                        (i_stat.kind == K_PAN) || (i_stat.kind == K_TO_SCREEN) ||
                        (i_stat.kind == K_TO_CANVAS) || (scale_kind && i_stat.scale_diff);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.axis  = r_axis;
        o_cmd.phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.load_prod = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.load_ns = 1'b1;
                n_state = S_DISP;
            end
            S_DISP: begin
                n_axis  = 1'b0;
                n_phase = 1'b0;
                n_state = need_arith ? S_START : S_COMMIT;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.arith_done) begin
                    if (scale_kind && !r_phase) begin
                        // focus in canvas space under the old scale, then redo with the new one
                        o_cmd.save_t = 1'b1;
                        n_phase = 1'b1;
                        n_state = S_START;
                    end else begin
                        o_cmd.write_res = 1'b1;
                        n_phase = 1'b0;
                        if (!r_axis) begin
                            n_axis  = 1'b1;
                            n_state = S_START;
                        end else begin
                            n_state = S_COMMIT;
                        end
                    end
                end
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_phase <= n_phase;
        end
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.arith_done |-> (r_state == S_WAIT))
        else $error("arith unit finished outside the wait state");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_stat.out_free)
        else $error("commit while result register still occupied");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after commit");

    a_phase_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_stat.kind == K_ZOOM || i_stat.kind == K_SET_SCALE))
        else $error("second division phase for a non-scale event");

endmodule

FILE: rtl/pan_zoom_viewport.sv
// Pan/zoom viewport block: origin and scale state with drag, pan, zoom and coordinate queries.
// Top level; instantiates pzv_ctrl and pzv_dp (which holds pzv_arith). Depends on pzv_pkg.
//
// Usage:
//   Events enter on the s_axis channel, one transfer per event; the event kind rides on
//   s_axis_tuser. Each event yields exactly one result transfer on m_axis carrying the
//   converted point (zero unless a query), the origin, the scale and the drag/moved flags.
//   Zoom limits are written on the cfg channel (index 0 minimum, index 1 maximum); the user must
//   write them only while no event is in flight (unchecked); cfg_ready is always high.
// Processing (N = COORD_WIDTH + FRAC_BITS + 1, 65 by default):
//   drag begin/end, unchanged zoom, idle drag move: no multiply or divide
//   pan, drag move, screen-to-canvas: one N-bit divide per axis
//   canvas-to-screen: one 24-bit multiply per axis
//   zoom or set scale that changes the scale: two N-bit divides per axis
//   Processing time is set by the shared bit-serial multiply/divide unit, used once per axis
//   (twice per axis for a scale change). One event is processed at a time.
// Reset: origin zero, scale 1.0, no drag, limits 0.1 and 4.0, no result pending.
// Stall: the finished result waits in the output register; the next event is accepted
//   and worked on, and its commit holds until the register is taken.
module pan_zoom_viewport import pzv_pkg::*; #(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    localparam int IN_TW  = ((2 * COORD_WIDTH + SCALE_W + 7) / 8) * 8,
    localparam int OUT_BW = 4 * COORD_WIDTH + SCALE_W + 2,
    localparam int OUT_TW = ((OUT_BW + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // x_in, y_in, amount (lowest bit up)
    input  logic [IN_TW-1:0]    s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_x, out_y, origin_x, origin_y, zoom_level, dragging, moved (lowest bit up)
    output logic [OUT_TW-1:0]   m_axis_tdata,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [SCALE_W-1:0]  i_cfg_data
);

    localparam int CW = COORD_WIDTH;

    t_cmd               cmd;
    t_stat              stat;
    logic [CW-1:0]      out_x, out_y, org_x, org_y;
    logic [SCALE_W-1:0] zoom;
    logic               drag, moved;

    pzv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pzv_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (s_axis_tuser),
        .i_x         (s_axis_tdata[CW-1:0]),
        .i_y         (s_axis_tdata[2*CW-1:CW]),
        .i_amt       (s_axis_tdata[2*CW+SCALE_W-1:2*CW]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_x     (out_x),
        .o_out_y     (out_y),
        .o_org_x     (org_x),
        .o_org_y     (org_y),
        .o_zoom      (zoom),
        .o_drag      (drag),
        .o_moved     (moved)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = OUT_TW'({moved, drag, zoom, org_y, org_x, out_y, out_x});

endmodule
